// ===== rtl/core/csub_pkg.sv =====
package csub_pkg;

    // table depth; the count width below follows from it
    localparam int RULE_ENTRIES = 16;
    localparam int COUNT_W      = $clog2(RULE_ENTRIES + 1);

    // channel and packed color widths
    localparam int CH_W  = 8;
    localparam int RGB_W = 3 * CH_W;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_COLOR = 1'b0,
        CFG_RES_COLOR = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        ACT_RULE  = 1'b0,
        ACT_PIXEL = 1'b1
    } t_action;

    typedef enum logic [2:0] {
        ST_REPLACED    = 3'd0,
        ST_PASSED      = 3'd1,
        ST_ADDED       = 3'd2,
        ST_OVERWRITTEN = 3'd3,
        ST_DROPPED     = 3'd4
    } t_status;

    // table lookup, from rule table to result formatting
    typedef struct packed {
        logic             hit;
        logic             full;
        logic [RGB_W-1:0] target;
    } t_lookup;

    // one formatted result word
    typedef struct packed {
        t_status         status;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_result;

endpackage

// ===== rtl/core/csub_rule_table.sv =====
module csub_rule_table (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr_en,
    input  logic                       i_src_color,
    input  logic [csub_pkg::RGB_W-1:0] i_key,
    input  logic [csub_pkg::RGB_W-1:0] i_target,
    output csub_pkg::t_lookup          o_lookup
);
    import csub_pkg::*;

    logic [RULE_ENTRIES-1:0] r_valid;
    logic [RGB_W-1:0]        r_source [RULE_ENTRIES];
    logic [RGB_W-1:0]        r_target [RULE_ENTRIES];
    logic [COUNT_W-1:0]      r_count;

    logic [RULE_ENTRIES-1:0] match;
    logic [RULE_ENTRIES-1:0] hit_oh;
    logic [RGB_W-1:0]        hit_target;
    logic                    full;
    logic                    add;

    // parallel compare; gray mode looks at red only
    always_comb begin
        for (int i = 0; i < RULE_ENTRIES; i++) begin
            match[i] = r_valid[i]
                && (r_source[i][RGB_W-1 -: CH_W] == i_key[RGB_W-1 -: CH_W])
                && (!i_src_color
                    || (r_source[i][RGB_W-CH_W-1:0] == i_key[RGB_W-CH_W-1:0]));
        end
    end

    // lowest matching entry wins
    assign hit_oh = match & (~match + RULE_ENTRIES'(1));

    always_comb begin
        hit_target = '0;
        for (int i = 0; i < RULE_ENTRIES; i++) begin
            hit_target = hit_target | (r_target[i] & {RGB_W{hit_oh[i]}});
        end
    end

    assign full = (r_count == COUNT_W'(RULE_ENTRIES));
    assign add  = i_wr_en && !(|match) && !full;

    assign o_lookup.hit    = |match;
    assign o_lookup.full   = full;
    assign o_lookup.target = hit_target;

    // valid bits and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
        end else if (add) begin
            for (int i = 0; i < RULE_ENTRIES; i++) begin
                if (r_count == COUNT_W'(i)) begin
                    r_valid[i] <= 1'b1;
                end
            end
            r_count <= r_count + COUNT_W'(1);
        end
    end

    // rule contents: overwrite on hit, append at fill count on a miss unless full
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < RULE_ENTRIES; i++) begin
            if (i_wr_en && hit_oh[i]) begin
                r_target[i] <= i_target;
            end else if (add && (r_count == COUNT_W'(i))) begin
                r_source[i] <= i_key;
                r_target[i] <= i_target;
            end
        end
    end

    // entries fill in order, so valid bits are a prefix of length r_count
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(RULE_ENTRIES))
        else $error("rule count beyond table depth");

    a_valid_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_count))
        else $error("valid bits disagree with rule count");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr_en && !full && !(|match)) |=> (r_count == $past(r_count) + COUNT_W'(1)))
        else $error("rule append did not advance count");

endmodule

// ===== rtl/core/csub_result_fmt.sv =====
module csub_result_fmt (
    input  logic                      i_action,
    input  logic                      i_src_color,
    input  logic                      i_res_color,
    input  logic [csub_pkg::CH_W-1:0] i_red,
    input  logic [csub_pkg::CH_W-1:0] i_green,
    input  logic [csub_pkg::CH_W-1:0] i_blue,
    input  csub_pkg::t_lookup         i_lookup,
    output csub_pkg::t_result         o_result
);
    import csub_pkg::*;

    logic [RGB_W-1:0] res;

    // color before output mode is applied
    always_comb begin
        if (i_lookup.hit) begin
            res = i_lookup.target;
        end else if (i_src_color) begin
            res = {i_red, i_green, i_blue};
        end else begin
            res = {i_red, i_red, i_red};
        end
    end

    always_comb begin
        o_result = '0;
        case (t_action'(i_action))
            ACT_RULE: begin
                if (i_lookup.hit) begin
                    o_result.status = ST_OVERWRITTEN;
                end else if (i_lookup.full) begin
                    o_result.status = ST_DROPPED;
                end else begin
                    o_result.status = ST_ADDED;
                end
            end
            ACT_PIXEL: begin
                o_result.status = i_lookup.hit ? ST_REPLACED : ST_PASSED;
                o_result.red    = res[RGB_W-1 -: CH_W];
                if (i_res_color) begin
                    o_result.green = res[2*CH_W-1 -: CH_W];
                    o_result.blue  = res[CH_W-1:0];
                end
            end
            default: begin
                o_result = '0;
            end
        endcase
    end

endmodule

// ===== rtl/core/color_substitution_table_unit.sv =====
// Color substitution table. One word is taken every clock cycle (o_busy never
// rises). Its result sits on the outputs with o_done high for exactly one
// cycle, after it has passed the input register and the result register.
// The receiver cannot stall, so it must take every strobe. The single-cycle
// rate is set by the parallel compare of the registered input word against
// all rule entries, whose update lands at the same edge, so a rule is seen
// by the very next word. Configuration writes are always ready and take
// effect at once; rules stay in the table across them.
module color_substitution_table_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic                            i_action,
    input  logic [csub_pkg::CH_W-1:0]       i_red,
    input  logic [csub_pkg::CH_W-1:0]       i_green,
    input  logic [csub_pkg::CH_W-1:0]       i_blue,
    input  logic [csub_pkg::CH_W-1:0]       i_new_red,
    input  logic [csub_pkg::CH_W-1:0]       i_new_green,
    input  logic [csub_pkg::CH_W-1:0]       i_new_blue,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [csub_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [csub_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                            o_done,
    output logic [2:0]                      o_status,
    output logic [csub_pkg::CH_W-1:0]       o_out_red,
    output logic [csub_pkg::CH_W-1:0]       o_out_green,
    output logic [csub_pkg::CH_W-1:0]       o_out_blue
);
    import csub_pkg::*;

    logic             r_src_color;
    logic             r_res_color;
    logic             r_in_valid;
    logic             r_action;
    logic [CH_W-1:0]  r_red;
    logic [CH_W-1:0]  r_green;
    logic [CH_W-1:0]  r_blue;
    logic [RGB_W-1:0] r_new;
    logic             r_done;
    t_result          r_result;

    logic             accept;
    t_lookup          lookup;
    t_result          n_result;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_start && !o_busy;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_color <= 1'b1;
            r_res_color <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SRC_COLOR: r_src_color <= i_cfg_data[0];
                CFG_RES_COLOR: r_res_color <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= i_action;
            r_red    <= i_red;
            r_green  <= i_green;
            r_blue   <= i_blue;
            r_new    <= {i_new_red, i_new_green, i_new_blue};
        end
    end

    csub_rule_table u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (r_in_valid && (r_action == ACT_RULE)),
        .i_src_color (r_src_color),
        .i_key       ({r_red, r_green, r_blue}),
        .i_target    (r_new),
        .o_lookup    (lookup)
    );

    csub_result_fmt u_fmt (
        .i_action    (r_action),
        .i_src_color (r_src_color),
        .i_res_color (r_res_color),
        .i_red       (r_red),
        .i_green     (r_green),
        .i_blue      (r_blue),
        .i_lookup    (lookup),
        .o_result    (n_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_result <= n_result;
        end
    end

    assign o_done      = r_done;
    assign o_status    = r_result.status;
    assign o_out_red   = r_result.red;
    assign o_out_green = r_result.green;
    assign o_out_blue  = r_result.blue;

    // every accepted word yields exactly one strobe, after the input and result registers
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ##1 o_done)
        else $error("accepted word produced no result");

    a_done_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, 2))
        else $error("result strobe without an accepted word");

    a_rule_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_ADDED || o_status == ST_OVERWRITTEN
                    || o_status == ST_DROPPED))
        |-> (o_out_red == '0 && o_out_green == '0 && o_out_blue == '0))
        else $error("rule write result carries a color");

endmodule
